// ===== rtl/lhcp_pkg.sv =====
// Shared types and field constants for the LFU heap cache policy unit.
`default_nettype none

package lhcp_pkg;

   // Fixed payload field widths
   localparam int KEY_FIELD_BITS   = 32;
   localparam int COUNT_FIELD_BITS = 16;

   // Beat widths; the tdata widths are whole bytes
   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 48;
   localparam int RSP_TUSER_BITS = 2;

   // Flag positions in rsp_tuser
   localparam int TUSER_HIT     = 0;
   localparam int TUSER_EVICTED = 1;

   // Sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCAN   = 8'b0000_0010,
      ST_DN_RDL = 8'b0000_0100,
      ST_DN_RDR = 8'b0000_1000,
      ST_DN_CMP = 8'b0001_0000,
      ST_UP_RD  = 8'b0010_0000,
      ST_UP_CMP = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lhcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lhcp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lfu_heap_cache_policy_unit.sv =====
// LFU cache replacement policy: key store kept as a binary min-heap on use counts.
// Steps: key scan of the occupied slots (ends at a hit); a hit sifts down (left read, right read,
//   compare per level); a miss sifts the new key up (parent read, compare per level), after
//   sifting the last entry down from the root if the store was full; then rsp is loaded.
// A new key is taken only in ST_IDLE, after the result is loaded; a held-off beat stalls ST_RESP.
// Reset (synchronous, active high) clears occupancy and handshake state only; the
//   RAM is not cleared, slots at or above occupancy are never read.
`default_nettype none

module lfu_heap_cache_policy_unit #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [lhcp_pkg::REQ_TDATA_BITS-1:0]  req_tdata,  // [31:0] block_key
   // response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [lhcp_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,  // [31:0] evicted_key,
                                                                 // [47:32] use_count
   output logic [lhcp_pkg::RSP_TUSER_BITS-1:0]       rsp_tuser   // [0] hit, [1] evicted
);

   import lhcp_pkg::*;

   // index widths: IW addresses a slot, OW holds a count up to CAPACITY,
   // XW holds child indexes up to 2*CAPACITY
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int XW = IW + 2;
   localparam int EW = KEY_BITS + COUNT_BITS;

   localparam logic [OW-1:0]         OCC_FULL  = OW'(CAPACITY);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   state_type state_ff, state_in;

   logic [OW-1:0]         occ_ff, occ_in;        // live heap size
   logic [OW-1:0]         heap_n_ff, heap_n_in;  // size used by the current sift-down
   logic [OW-1:0]         scan_ff, scan_in;      // next slot to read in the scan
   logic                  chk_vld_ff, chk_vld_in;
   logic [IW-1:0]         chk_idx_ff, chk_idx_in;
   logic [IW-1:0]         pos_ff, pos_in;        // hole position
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   held_key_ff, held_key_in;   // entry that moves through the heap
   logic [COUNT_BITS-1:0] held_cnt_ff, held_cnt_in;
   logic                  cand_child_ff, cand_child_in; // best of held/left child so far
   logic [IW-1:0]         cand_idx_ff, cand_idx_in;
   logic [KEY_BITS-1:0]   cand_key_ff, cand_key_in;
   logic [COUNT_BITS-1:0] cand_cnt_ff, cand_cnt_in;
   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic [KEY_BITS-1:0]   ev_key_ff, ev_key_in;
   logic [COUNT_BITS-1:0] res_cnt_ff, res_cnt_in;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [KEY_FIELD_BITS-1:0]   rsp_evk_ff, rsp_evk_in;
   logic [COUNT_FIELD_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;

   // RAM ports
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [COUNT_BITS-1:0] rd_cnt_inc;
   logic [63:0]           req_key_wide;
   logic [63:0]           evk_wide;
   logic [31:0]           cnt_wide;

   // shared count comparator and heap index arithmetic
   logic [COUNT_BITS-1:0] cmp_a;
   logic                  cnt_lt;
   logic                  key_eq;
   logic [XW-1:0]         lc_x, rc_x, n_x;
   logic [IW-1:0]         par_idx;

   // sift-down level decision
   logic                  win_child;
   logic [IW-1:0]         win_idx;
   logic [KEY_BITS-1:0]   win_key;
   logic [COUNT_BITS-1:0] win_cnt;
   logic                  dn_decide;
   logic                  dn_done;

   lhcp_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key       = rd_data[EW-1:COUNT_BITS];
   assign rd_cnt       = rd_data[COUNT_BITS-1:0];
   assign rd_cnt_inc   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;
   assign req_key_wide = 64'(req_tdata);

   assign cmp_a  = (state_ff == ST_DN_CMP) ? cand_cnt_ff : held_cnt_ff;
   assign cnt_lt = cmp_a < rd_cnt;
   assign key_eq = rd_key == key_ff;

   assign lc_x    = (XW'(pos_ff) << 1) + XW'(1);
   assign rc_x    = lc_x + XW'(1);
   assign n_x     = XW'(heap_n_ff);
   assign par_idx = (pos_ff - IW'(1)) >> 1;

   // which of held / children takes the hole at this level
   always_comb begin
      if (state_ff == ST_DN_CMP) begin
         if (cnt_lt) begin
            win_child = cand_child_ff;
            win_idx   = cand_idx_ff;
            win_key   = cand_key_ff;
            win_cnt   = cand_cnt_ff;
         end else begin
            win_child = 1'b1;
            win_idx   = rc_x[IW-1:0];
            win_key   = rd_key;
            win_cnt   = rd_cnt;
         end
      end else begin
         win_child = !cnt_lt;
         win_idx   = lc_x[IW-1:0];
         win_key   = rd_key;
         win_cnt   = rd_cnt;
      end
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      heap_n_in     = heap_n_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      held_key_in   = held_key_ff;
      held_cnt_in   = held_cnt_ff;
      cand_child_in = cand_child_ff;
      cand_idx_in   = cand_idx_ff;
      cand_key_in   = cand_key_ff;
      cand_cnt_in   = cand_cnt_ff;
      hit_in        = hit_ff;
      evict_in      = evict_ff;
      ev_key_in     = ev_key_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evk_in    = rsp_evk_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {held_key_ff, held_cnt_ff};
      rd_addr       = pos_ff;
      dn_decide     = 1'b0;
      dn_done       = 1'b0;
      evk_wide      = 64'(ev_key_ff);
      cnt_wide      = 32'(res_cnt_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in     = req_key_wide[KEY_BITS-1:0];
               hit_in     = 1'b0;
               evict_in   = 1'b0;
               res_cnt_in = COUNT_ONE;
               if (occ_ff == '0) begin
                  // empty store: new key goes straight to the root
                  pos_in      = '0;
                  held_key_in = req_key_wide[KEY_BITS-1:0];
                  held_cnt_in = COUNT_ONE;
                  occ_in      = OW'(1);
                  state_in    = ST_UP_RD;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // one slot read per cycle, compare in the next cycle
            if (scan_ff < occ_ff) begin
               rd_addr    = scan_ff[IW-1:0];
               scan_in    = scan_ff + OW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
            end
            if (chk_vld_ff) begin
               if (chk_idx_ff == '0) begin
                  ev_key_in = rd_key;
               end
               if (key_eq) begin
                  hit_in      = 1'b1;
                  held_key_in = key_ff;
                  held_cnt_in = rd_cnt_inc;
                  res_cnt_in  = rd_cnt_inc;
                  pos_in      = chk_idx_ff;
                  heap_n_in   = occ_ff;
                  chk_vld_in  = 1'b0;
                  state_in    = ST_DN_RDL;
               end else if (OW'(chk_idx_ff) == occ_ff - OW'(1)) begin
                  chk_vld_in = 1'b0;
                  if (occ_ff == OCC_FULL) begin
                     // last entry (on the read port now) refills the root
                     evict_in    = 1'b1;
                     held_key_in = rd_key;
                     held_cnt_in = rd_cnt;
                     pos_in      = '0;
                     heap_n_in   = occ_ff - OW'(1);
                     state_in    = ST_DN_RDL;
                  end else begin
                     held_key_in = key_ff;
                     held_cnt_in = COUNT_ONE;
                     pos_in      = occ_ff[IW-1:0];
                     occ_in      = occ_ff + OW'(1);
                     state_in    = ST_UP_RD;
                  end
               end
            end
         end

         ST_DN_RDL: begin
            if (lc_x < n_x) begin
               rd_addr  = lc_x[IW-1:0];
               state_in = ST_DN_RDR;
            end else begin
               dn_done = 1'b1;
            end
         end

         ST_DN_RDR: begin
            if (rc_x < n_x) begin
               rd_addr       = rc_x[IW-1:0];
               cand_child_in = !cnt_lt;
               cand_idx_in   = lc_x[IW-1:0];
               cand_key_in   = cnt_lt ? held_key_ff : rd_key;
               cand_cnt_in   = cnt_lt ? held_cnt_ff : rd_cnt;
               state_in      = ST_DN_CMP;
            end else begin
               dn_decide = 1'b1;
            end
         end

         ST_DN_CMP: begin
            dn_decide = 1'b1;
         end

         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_addr  = par_idx;
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cnt_lt) begin
               // parent strictly greater: parent drops into the hole
               wr_data  = rd_data;
               pos_in   = par_idx;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_ev_in  = evict_ff;
               rsp_evk_in = evict_ff ? evk_wide[KEY_FIELD_BITS-1:0] : '0;
               rsp_cnt_in = cnt_wide[COUNT_FIELD_BITS-1:0];
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // close one sift-down level
      if (dn_decide) begin
         wr_en = 1'b1;
         if (win_child) begin
            wr_data  = {win_key, win_cnt};
            pos_in   = win_idx;
            state_in = ST_DN_RDL;
         end else begin
            dn_done = 1'b1;
         end
      end

      // held entry settles; on eviction the new key then rises from the tail
      if (dn_done) begin
         wr_en = 1'b1;
         if (evict_ff) begin
            pos_in      = heap_n_ff[IW-1:0];
            held_key_in = key_ff;
            held_cnt_in = COUNT_ONE;
            state_in    = ST_UP_RD;
         end else begin
            state_in = ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         occ_ff     <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         occ_ff     <= occ_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      heap_n_ff     <= heap_n_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      held_key_ff   <= held_key_in;
      held_cnt_ff   <= held_cnt_in;
      cand_child_ff <= cand_child_in;
      cand_idx_ff   <= cand_idx_in;
      cand_key_ff   <= cand_key_in;
      cand_cnt_ff   <= cand_cnt_in;
      hit_ff        <= hit_in;
      evict_ff      <= evict_in;
      ev_key_ff     <= ev_key_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evk_ff    <= rsp_evk_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_evk_ff};
   assign rsp_tuser  = {rsp_ev_ff, rsp_hit_ff};

   // heap never grows past its capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy above capacity");

   // slot writes stay inside the live heap
   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (OW'(wr_addr) < occ_ff))
      else $error("slot write beyond occupancy");

   // the scan only compares occupied slots
   a_scan_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_vld_ff) |-> (OW'(chk_idx_ff) < occ_ff))
      else $error("scan compared an unoccupied slot");

   // an eviction only happens on a miss
   a_ev_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_ev_ff && rsp_hit_ff))
      else $error("evicted on a hit");

   // a finished reference always reports a nonzero count
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> (res_cnt_ff != '0))
      else $error("zero use count");

endmodule

`default_nettype wire

// ===== test/lfu_heap_cache_policy_unit_tb.sv =====
// Self-checking testbench for the LFU heap cache policy unit: directed table, then random keys.
`default_nettype none

module lfu_heap_cache_policy_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lhcp_pkg::*;

   // The unit runs at its default widths; counts stay well below saturation in a run this long.
   localparam int HEAP_SLOTS = 16;
   localparam int CNT_BITS   = COUNT_FIELD_BITS;
   localparam logic [COUNT_FIELD_BITS-1:0] CNT_MAX = COUNT_FIELD_BITS'((1 << CNT_BITS) - 1);

   localparam int POOL_KEYS  = 24;     // working set per phase
   localparam int HOT_KEYS   = 6;      // most-referenced part of the working set
   localparam int PHASE_KEYS = 360;    // random beats per idling phase
   localparam int HOLD_CYCLES = 400;   // long sink hold-off, fills the unit
   localparam int DRAIN_CYCLES = 64;   // idle margin after the last expected beat
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic                        hit;
      logic                        evicted;
      logic [KEY_FIELD_BITS-1:0]   evicted_key;
      logic [COUNT_FIELD_BITS-1:0] use_count;
   } lookup_type;

   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0] key;
      logic                      typed;   // want below is hand-written, else predictor
      lookup_type                want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;   // [31:0] block_key
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;        // [31:0] evicted_key, [47:32] use_count
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;        // [0] hit, [1] evicted

   lfu_heap_cache_policy_unit #(
      .CAPACITY  (HEAP_SLOTS),
      .KEY_BITS  (KEY_FIELD_BITS),
      .COUNT_BITS(CNT_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow heap: same layout as the unit's store, slot 0 is the root
   // ---------------------------------------------------------------------------------------
   logic [KEY_FIELD_BITS-1:0]   heap_key [HEAP_SLOTS];
   logic [COUNT_FIELD_BITS-1:0] heap_cnt [HEAP_SLOTS];
   int                          heap_fill = 0;

   lookup_type  pending_lookups [$];   // expected response beats, oldest first
   dir_row_type dir_rows [$];
   logic [KEY_FIELD_BITS-1:0] key_pool [POOL_KEYS];

   int  bad_beats = 0;
   int  src_idle_pct = 0;
   int  sink_stall_pct = 0;
   bit  hold_req = 1'b0;

   function automatic void swap_slots(input int a, input int b);
      logic [KEY_FIELD_BITS-1:0]   k;
      logic [COUNT_FIELD_BITS-1:0] c;
      k = heap_key[a];
      c = heap_cnt[a];
      heap_key[a] = heap_key[b];
      heap_cnt[a] = heap_cnt[b];
      heap_key[b] = k;
      heap_cnt[b] = c;
   endfunction

   // Compare left child first, then right; on a tie the child wins, right over left.
   function automatic void sink_entry(input int start, input int n);
      int pos;
      int best;
      pos = start;
      while (pos < n) begin
         best = pos;
         if (2 * pos + 1 < n)
            best = (heap_cnt[pos] < heap_cnt[2 * pos + 1]) ? pos : 2 * pos + 1;
         if (2 * pos + 2 < n)
            best = (heap_cnt[best] < heap_cnt[2 * pos + 2]) ? best : 2 * pos + 2;
         if (best == pos)
            break;
         swap_slots(best, pos);
         pos = best;
      end
   endfunction

   // One reference: updates the shadow heap, returns the beat the unit should send.
   function automatic lookup_type lfu_lookup(input logic [KEY_FIELD_BITS-1:0] key);
      lookup_type r;
      int      n;
      int      found;
      int      pos;
      int      par;
      r = '0;
      n = heap_fill;
      found = n;
      for (int s = 0; s < n; s++) begin
         if (found == n && heap_key[s] == key)
            found = s;
      end
      if (found < n) begin
         r.hit = 1'b1;
         if (heap_cnt[found] < CNT_MAX)
            heap_cnt[found] = heap_cnt[found] + 1'b1;
         r.use_count = heap_cnt[found];
         sink_entry(found, n);
      end else begin
         if (n == HEAP_SLOTS) begin
            // full store: drop the root, last entry takes its place
            r.evicted = 1'b1;
            r.evicted_key = heap_key[0];
            n = n - 1;
            heap_key[0] = heap_key[n];
            heap_cnt[0] = heap_cnt[n];
            sink_entry(0, n);
         end
         pos = n;
         heap_key[pos] = key;
         heap_cnt[pos] = COUNT_FIELD_BITS'(1);
         n = n + 1;
         // rise only past a strictly larger parent
         while (pos > 0) begin
            par = (pos - 1) / 2;
            if (heap_cnt[par] <= heap_cnt[pos])
               break;
            swap_slots(par, pos);
            pos = par;
         end
         r.use_count = COUNT_FIELD_BITS'(1);
      end
      heap_fill = n;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side: starts and ends at a falling edge
   // ---------------------------------------------------------------------------------------
   task automatic offer_key(input logic [KEY_FIELD_BITS-1:0] key, input logic typed,
                            input lookup_type want);
      lookup_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // beat taken at this edge
      predicted = lfu_lookup(key);
      pending_lookups.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic add_row(input logic [KEY_FIELD_BITS-1:0] key, input logic typed,
                          input logic hit, input logic evicted, input int cnt);
      lookup_type w;
      w = '{hit: hit, evicted: evicted, evicted_key: '0,
            use_count: COUNT_FIELD_BITS'(cnt)};
      dir_rows.push_back('{key: key, typed: typed, want: w});
   endtask

   function automatic logic [KEY_FIELD_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return key_pool[$urandom_range(HOT_KEYS - 1)];
      else if (r < 90)
         return key_pool[$urandom_range(POOL_KEYS - 1, HOT_KEYS)];
      return $urandom();   // stray key, nearly always a miss
   endfunction

   // ---------------------------------------------------------------------------------------
   // Response side: ready changes at the falling edge, beats checked at the rising edge
   // ---------------------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++)
               @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         bad_beats++;
         if (bad_beats <= SHOW_LIMIT)
            $display("%0t %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      lookup_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            bad_beats++;
            if (bad_beats <= SHOW_LIMIT)
               $display("%0t response beat with nothing outstanding: %h/%h",
                        $realtime, rsp_tuser, rsp_tdata);
         end else begin
            exp_beat = pending_lookups.pop_front();
            check_field("hit", 32'(exp_beat.hit), 32'(rsp_tuser[TUSER_HIT]));
            check_field("evicted", 32'(exp_beat.evicted), 32'(rsp_tuser[TUSER_EVICTED]));
            check_field("evicted_key", exp_beat.evicted_key, rsp_tdata[KEY_FIELD_BITS-1:0]);
            check_field("use_count", 32'(exp_beat.use_count),
                        32'(rsp_tdata[KEY_FIELD_BITS +: COUNT_FIELD_BITS]));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int src_pct  [4] = '{0, 71, 0, 13};
      int sink_pct [4] = '{0, 0, 71, 13};

      // first reference after reset, then key 0 climbs a few counts
      add_row(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'h0000_0000, 1'b1, 1'b1, 1'b0, 2);
      add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1);   // rises above key 0
      for (int c = 3; c <= 6; c++)
         add_row(32'h0000_0000, 1'b1, 1'b1, 1'b0, c);
      add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 2);
      // fill the store; new count-1 entries rise past larger parents, stay below count-1 ones
      add_row(32'h0000_0001, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'h8000_0000, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'h5555_5555, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1);
      add_row(32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 1);
      for (int k = 2; k <= 9; k++)
         add_row(k, 1'b1, 1'b0, 1'b0, 1);
      // store full: evict the root, last entry sinks from the top
      add_row(32'h1234_5678, 1'b0, 1'b0, 1'b0, 0);
      add_row(32'h0000_0001, 1'b0, 1'b0, 1'b0, 0);   // key evicted just before: a miss that evicts again

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         offer_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < 4; p++) begin
         src_idle_pct   = src_pct[p];
         sink_stall_pct = sink_pct[p];
         for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = $urandom();
         if (p == 0)
            hold_req = 1'b1;   // sink goes quiet while the sender keeps offering
         for (int i = 0; i < PHASE_KEYS; i++)
            offer_key(pick_key(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_beats == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
